@@ design/dsv_pkg.sv @@
// ----------------------------------------------------------------------------
// D-Bus signature validator package
// Shared types, character codes and helpers of the signature validator.
// ----------------------------------------------------------------------------
package dsv_pkg;

    localparam int unsigned MAX_ARRAY_NEST_DEF  = 32;
    localparam int unsigned MAX_STRUCT_NEST_DEF = 32;
    localparam int unsigned STACK_FRAMES_DEF    = 64;

    localparam logic [7:0] CH_NUL     = 8'h00;
    localparam logic [7:0] CH_VARIANT = 8'h76;  // v
    localparam logic [7:0] CH_LPAREN  = 8'h28;  // (
    localparam logic [7:0] CH_RPAREN  = 8'h29;  // )
    localparam logic [7:0] CH_ARRAY   = 8'h61;  // a
    localparam logic [7:0] CH_LBRACE  = 8'h7b;  // {
    localparam logic [7:0] CH_RBRACE  = 8'h7d;  // }

    localparam logic [1:0] VERDICT_PENDING = 2'd0;
    localparam logic [1:0] VERDICT_VALID   = 2'd1;
    localparam logic [1:0] VERDICT_INVALID = 2'd2;

    typedef enum logic [2:0] {
        FR_STRUCT_EMPTY = 3'd0,
        FR_STRUCT_SOME  = 3'd1,
        FR_ARRAY        = 3'd2,
        FR_DICT_KEY     = 3'd3,
        FR_DICT_VAL     = 3'd4,
        FR_DICT_CLOSE   = 3'd5
    } frame_t;

    typedef enum logic [1:0] {
        ACT_FINISH    = 2'd0,
        ACT_TYPE_DONE = 2'd1,
        ACT_POP_READ  = 2'd2
    } act_t;

    typedef struct packed {
        logic load_char;
        logic exec;
        logic load_top;
        logic td_step;
        logic out_load;
    } dp_cmd_t;

    typedef struct packed {
        act_t act;
    } dp_status_t;

    function automatic logic is_basic(input logic [7:0] c);
        logic r;
        case (c)
            8'h79, 8'h62, 8'h6e, 8'h71, 8'h69, 8'h75, 8'h78,
            8'h74, 8'h64, 8'h73, 8'h6f, 8'h67, 8'h68: r = 1'b1;
            default: r = 1'b0;
        endcase
        return r;
    endfunction

endpackage

@@ design/dsv_ctrl.sv @@
// ----------------------------------------------------------------------------
// Signature validator controller
// Sequences input transfers, byte execution, stack pops and output loads.
// ----------------------------------------------------------------------------
module dsv_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    output logic                m_tvalid,
    input  logic                m_tready,
    output dsv_pkg::dp_cmd_t    cmd,
    input  dsv_pkg::dp_status_t status
);

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_EXEC = 5'b00010,
        ST_LOAD = 5'b00100,
        ST_TD   = 5'b01000,
        ST_DONE = 5'b10000
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;
    logic   out_free;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign out_free = !m_valid_reg || m_tready;

    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg;
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                case (status.act)
                    dsv_pkg::ACT_TYPE_DONE: state_next = ST_TD;
                    dsv_pkg::ACT_POP_READ:  state_next = ST_LOAD;
                    default:                state_next = ST_DONE;
                endcase
            end
            ST_LOAD: begin
                state_next = ST_TD;
            end
            ST_TD: begin
                case (status.act)
                    dsv_pkg::ACT_TYPE_DONE: state_next = ST_TD;
                    dsv_pkg::ACT_POP_READ:  state_next = ST_LOAD;
                    default:                state_next = ST_DONE;
                endcase
            end
            ST_DONE: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd = '0;
        case (state_reg)
            ST_IDLE: cmd.load_char = s_tvalid;
            ST_EXEC: cmd.exec      = 1'b1;
            ST_LOAD: cmd.load_top  = 1'b1;
            ST_TD:   cmd.td_step   = 1'b1;
            ST_DONE: cmd.out_load  = out_free;
            default: cmd           = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

@@ design/dsv_datapath.sv @@
// ----------------------------------------------------------------------------
// Signature validator datapath
// Frame stack memory, top frame register, nesting counters and result register.
// ----------------------------------------------------------------------------
module dsv_datapath #(
    parameter int unsigned MAX_ARRAY_NEST  = dsv_pkg::MAX_ARRAY_NEST_DEF,
    parameter int unsigned MAX_STRUCT_NEST = dsv_pkg::MAX_STRUCT_NEST_DEF,
    parameter int unsigned STACK_FRAMES    = dsv_pkg::STACK_FRAMES_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_wr_en,
    input  logic                cfg_wr_data,
    input  logic [7:0]          code_char,
    input  dsv_pkg::dp_cmd_t    cmd,
    output dsv_pkg::dp_status_t status,
    output logic [1:0]          verdict,
    output logic                done_res
);

    localparam int unsigned LVL_W = $clog2(STACK_FRAMES + 1);
    localparam int unsigned AW    = $clog2(STACK_FRAMES);
    localparam int unsigned AL_W  = $clog2(MAX_ARRAY_NEST + 1);
    localparam int unsigned SL_W  = $clog2(MAX_STRUCT_NEST + 1);

    dsv_pkg::frame_t mem [STACK_FRAMES];
    dsv_pkg::frame_t rd_data_reg;

    logic             mode_reg, mode_next;
    logic [7:0]       char_reg;
    logic [LVL_W-1:0] lvl_reg, lvl_next;
    logic [AL_W-1:0]  arr_reg, arr_next;
    logic [SL_W-1:0]  str_reg, str_next;
    dsv_pkg::frame_t  top_reg, top_next;
    logic             seen_reg, seen_next;
    logic             err_reg, err_next;
    logic             term_ok_reg, term_ok_next;
    logic [1:0]       verdict_reg;
    logic             done_reg;

    logic             push;
    logic [LVL_W-1:0] lvl_dec;
    logic [LVL_W-1:0] lvl_wr;
    logic [LVL_W-1:0] lvl_rd;
    logic             has_top;
    logic             new_type;
    dsv_pkg::act_t    pop_act;
    logic [AL_W-1:0]  arr_dec;
    logic [SL_W-1:0]  str_dec;

    assign lvl_dec = lvl_reg - LVL_W'(1);
    assign has_top = (lvl_reg != '0);
    assign pop_act = (lvl_dec == '0) ? dsv_pkg::ACT_TYPE_DONE : dsv_pkg::ACT_POP_READ;
    assign arr_dec = (arr_reg != '0) ? arr_reg - AL_W'(1) : arr_reg;
    assign str_dec = (str_reg != '0) ? str_reg - SL_W'(1) : str_reg;

    always_comb begin
        mode_next    = cfg_wr_en ? cfg_wr_data : mode_reg;
        lvl_next     = lvl_reg;
        arr_next     = arr_reg;
        str_next     = str_reg;
        top_next     = top_reg;
        seen_next    = seen_reg;
        err_next     = err_reg;
        term_ok_next = term_ok_reg;
        push         = 1'b0;
        new_type     = 1'b0;
        status.act   = dsv_pkg::ACT_FINISH;

        if (cmd.exec) begin
            if (char_reg == dsv_pkg::CH_NUL) begin
                term_ok_next = !err_reg && !has_top && (!mode_reg || seen_reg);
                lvl_next     = '0;
                arr_next     = '0;
                str_next     = '0;
                seen_next    = 1'b0;
                err_next     = 1'b0;
            end else if (!err_reg) begin
                if (has_top && top_reg == dsv_pkg::FR_DICT_KEY) begin
                    if (dsv_pkg::is_basic(char_reg)) begin
                        top_next = dsv_pkg::FR_DICT_VAL;
                    end else begin
                        err_next = 1'b1;
                    end
                end else if (has_top && top_reg == dsv_pkg::FR_DICT_CLOSE) begin
                    if (char_reg != dsv_pkg::CH_RBRACE) begin
                        err_next = 1'b1;
                    end else begin
                        lvl_next   = lvl_dec;
                        str_next   = str_dec;
                        arr_next   = arr_dec;
                        status.act = pop_act;
                    end
                end else if (has_top && top_reg == dsv_pkg::FR_ARRAY &&
                             char_reg == dsv_pkg::CH_LBRACE) begin
                    if (str_reg >= SL_W'(MAX_STRUCT_NEST)) begin
                        err_next = 1'b1;
                    end else begin
                        str_next = str_reg + SL_W'(1);
                        top_next = dsv_pkg::FR_DICT_KEY;
                    end
                end else if (char_reg == dsv_pkg::CH_RPAREN) begin
                    if (!(has_top && top_reg == dsv_pkg::FR_STRUCT_SOME)) begin
                        err_next = 1'b1;
                    end else begin
                        lvl_next   = lvl_dec;
                        str_next   = str_dec;
                        status.act = pop_act;
                    end
                end else if (!has_top && mode_reg && seen_reg) begin
                    err_next = 1'b1;
                end else if (dsv_pkg::is_basic(char_reg) ||
                             char_reg == dsv_pkg::CH_VARIANT) begin
                    status.act = dsv_pkg::ACT_TYPE_DONE;
                end else if (char_reg == dsv_pkg::CH_LPAREN) begin
                    if (str_reg >= SL_W'(MAX_STRUCT_NEST) ||
                        lvl_reg >= LVL_W'(STACK_FRAMES)) begin
                        err_next = 1'b1;
                    end else begin
                        str_next = str_reg + SL_W'(1);
                        new_type = 1'b1;
                        top_next = dsv_pkg::FR_STRUCT_EMPTY;
                    end
                end else if (char_reg == dsv_pkg::CH_ARRAY) begin
                    if (arr_reg >= AL_W'(MAX_ARRAY_NEST) ||
                        lvl_reg >= LVL_W'(STACK_FRAMES)) begin
                        err_next = 1'b1;
                    end else begin
                        arr_next = arr_reg + AL_W'(1);
                        new_type = 1'b1;
                        top_next = dsv_pkg::FR_ARRAY;
                    end
                end else begin
                    err_next = 1'b1;
                end
                if (new_type) begin
                    push     = has_top;
                    lvl_next = lvl_reg + LVL_W'(1);
                end
            end
        end

        if (cmd.load_top) begin
            top_next = rd_data_reg;
        end

        if (cmd.td_step) begin
            if (!has_top) begin
                seen_next = 1'b1;
            end else begin
                case (top_reg)
                    dsv_pkg::FR_STRUCT_EMPTY,
                    dsv_pkg::FR_STRUCT_SOME: top_next = dsv_pkg::FR_STRUCT_SOME;
                    dsv_pkg::FR_DICT_VAL:    top_next = dsv_pkg::FR_DICT_CLOSE;
                    dsv_pkg::FR_ARRAY: begin
                        lvl_next   = lvl_dec;
                        arr_next   = arr_dec;
                        status.act = pop_act;
                    end
                    default: err_next = 1'b1;
                endcase
            end
        end
    end

    assign lvl_wr = lvl_dec;
    assign lvl_rd = (lvl_next != '0) ? lvl_next - LVL_W'(1) : '0;

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[lvl_wr[AW-1:0]] <= top_reg;
        end
        rd_data_reg <= mem[lvl_rd[AW-1:0]];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= 1'b0;
            lvl_reg  <= '0;
            arr_reg  <= '0;
            str_reg  <= '0;
            seen_reg <= 1'b0;
            err_reg  <= 1'b0;
        end else begin
            mode_reg <= mode_next;
            lvl_reg  <= lvl_next;
            arr_reg  <= arr_next;
            str_reg  <= str_next;
            seen_reg <= seen_next;
            err_reg  <= err_next;
        end
    end

    always_ff @(posedge aclk) begin
        top_reg     <= top_next;
        term_ok_reg <= term_ok_next;
        if (cmd.load_char) begin
            char_reg <= code_char;
        end
        if (cmd.out_load) begin
            done_reg <= (char_reg == dsv_pkg::CH_NUL);
            if (char_reg == dsv_pkg::CH_NUL) begin
                verdict_reg <= term_ok_reg ? dsv_pkg::VERDICT_VALID
                                           : dsv_pkg::VERDICT_INVALID;
            end else begin
                verdict_reg <= err_reg ? dsv_pkg::VERDICT_INVALID
                                       : dsv_pkg::VERDICT_PENDING;
            end
        end
    end

    assign verdict  = verdict_reg;
    assign done_res = done_reg;

endmodule

@@ design/dbus_signature_validator.sv @@
// ----------------------------------------------------------------------------
// D-Bus signature validator
// Checks a D-Bus type signature streamed one byte per transfer.
// ----------------------------------------------------------------------------
// Each input transfer carries one signature byte; a zero byte ends the
// signature. Every input transfer yields exactly one output transfer holding
// the running verdict (pending or invalid) and, for the terminator, the final
// verdict with m_tlast set. The mode register selects between any sequence of
// complete types and exactly one complete type; it is written with cfg_wr_en.
// The user must write it only while the block is idle; the block itself does
// not enforce this. Each byte is captured on its input transfer, executed,
// and its result loaded into the output register. Each further step of
// closing a type adds a type-done step, and each nested frame that closes
// below the top adds a load of the frame below via the registered stack read.
// The block takes the next byte while a result waits in the output register;
// if the receiver stalls, processing holds before loading the next result.
// After reset the mode is zero, the stack is empty and no result is pending.
// ----------------------------------------------------------------------------
module dbus_signature_validator #(
    parameter int unsigned MAX_ARRAY_NEST  = dsv_pkg::MAX_ARRAY_NEST_DEF,
    parameter int unsigned MAX_STRUCT_NEST = dsv_pkg::MAX_STRUCT_NEST_DEF,
    parameter int unsigned STACK_FRAMES    = dsv_pkg::STACK_FRAMES_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_wr_en,
    input  logic       cfg_wr_data,   // signature_mode
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,       // code_char
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,       // verdict [1:0], zero fill above
    output logic       m_tlast        // done_res
);

    dsv_pkg::dp_cmd_t    cmd;
    dsv_pkg::dp_status_t status;
    logic [1:0]          verdict;

    dsv_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .status   (status)
    );

    dsv_datapath #(
        .MAX_ARRAY_NEST  (MAX_ARRAY_NEST),
        .MAX_STRUCT_NEST (MAX_STRUCT_NEST),
        .STACK_FRAMES    (STACK_FRAMES)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .code_char   (s_tdata),
        .cmd         (cmd),
        .status      (status),
        .verdict     (verdict),
        .done_res    (m_tlast)
    );

    assign m_tdata = {6'd0, verdict};

endmodule
